>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes shared by the first-fit block allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // widths of the request and response fields
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SIZE_W = 24;
    localparam int unsigned HDR_W  = 8;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_ZALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_ROOM  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [ST_W-1:0] ST_TOO_BIG  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'd1;

    // reset value of the header size
    localparam logic [HDR_W-1:0] HEADER_RESET = 8'd32;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SIZE_W-1:0] request_size;
        logic [SIZE_W-1:0] element_count;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] payload_address;
        logic [SIZE_W-1:0] granted_size;
        logic              reused_block;
        logic              zero_fill;
    } t_rsp;

    // one block table entry
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] length;
        logic              in_use;
    } t_entry;

endpackage

>>> design/ffba_req_if.sv
// ----------------------------------------------------------------------------
// ffba_req_if
// Valid/ready channel carrying allocator requests.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    import ffba_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/ffba_rsp_if.sv
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Valid/ready channel carrying allocator responses.
// ----------------------------------------------------------------------------
interface ffba_rsp_if;
    import ffba_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  ffba_pkg::t_entry       i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output ffba_pkg::t_entry       o_rdata
);
    import ffba_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator with a table of blocks kept in address order.
// ----------------------------------------------------------------------------
// One request is handled at a time. The block table sits in a memory with one
// write port and one read port that is scanned one entry per cycle. An
// allocate or free scans the table; a zeroed allocate first runs a registered
// 24x24 multiply and overflow check (an overflowing one ends after the check),
// and appending a new block at the heap top adds an address and a place step.
// An ignored operation code goes straight to the response. The scan through
// the table's one read port sets the length of a request. A finished response
// waits in an output register, and the next request is accepted while it
// waits. There are no splits or merges of blocks; zero_fill only tells the
// requester to clear the payload.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ffba_req_if.sink                         i_req,
    ffba_rsp_if.source                       o_rsp,
    input  logic                             i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ffba_pkg::ADDR_W-1:0]      i_cfg_data
);
    import ffba_pkg::*;

    localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
    localparam logic [ADDR_W+1:0] ADDR_END = {2'b01, {ADDR_W{1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_CHK   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_ADDR  = 7'b0010000,
        S_PLACE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]   r_heap_base;
    logic [HDR_W-1:0]    r_header;
    logic [CW-1:0]       r_total;
    logic [ADDR_W:0]     r_heap_top;

    logic [OP_W-1:0]     r_op;
    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   r_count;
    logic [ADDR_W-1:0]   r_addr;
    logic [2*SIZE_W-1:0] r_prod;
    logic [CW-1:0]       r_idx;
    logic                r_chk;
    logic [IW-1:0]       r_chk_idx;
    logic [ADDR_W:0]     r_payload;
    t_rsp                r_res;
    logic                r_out_valid;
    t_rsp                r_out;

    t_entry              rd_entry;
    logic                tbl_we;
    logic [IW-1:0]       tbl_waddr;
    t_entry              tbl_wdata;

    logic                accept;
    logic                is_free;
    logic                hit;
    logic                scan_more;
    logic                scan_end;
    logic [ADDR_W:0]     top_sel;
    logic [ADDR_W+1:0]   end_addr;
    logic                place_ok;
    logic                out_free;

    // block table
    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rd_entry)
    );

    // handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // shared compare unit used by the scan
    assign is_free   = (r_op == OP_FREE);
    assign hit       = r_chk && (is_free ? (rd_entry.base == r_addr)
                                         : (!rd_entry.in_use && rd_entry.length >= r_size));
    assign scan_more = (r_idx < r_total);
    assign scan_end  = !r_chk && !scan_more;

    // heap top and end of the appended block
    assign top_sel  = (r_total == '0) ? {1'b0, r_heap_base} : r_heap_top;
    assign end_addr = {1'b0, r_payload} + {{(ADDR_W+2-SIZE_W){1'b0}}, r_size};
    assign place_ok = !r_payload[ADDR_W] && (end_addr <= ADDR_END);

    // table writes: mark on a hit, new entry on an append
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_chk_idx;
        tbl_wdata = rd_entry;
        if (r_state == S_SCAN && hit) begin
            tbl_we           = 1'b1;
            tbl_wdata.in_use = !is_free;
        end else if (r_state == S_PLACE && place_ok) begin
            tbl_we           = 1'b1;
            tbl_waddr        = r_total[IW-1:0];
            tbl_wdata.base   = r_payload[ADDR_W-1:0];
            tbl_wdata.length = r_size;
            tbl_wdata.in_use = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.payload.operation)
                        OP_ALLOC:  n_state = S_SCAN;
                        OP_ZALLOC: n_state = S_MUL;
                        OP_FREE:   n_state = S_SCAN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_MUL:   n_state = S_CHK;
            S_CHK:   n_state = (r_prod[2*SIZE_W-1:SIZE_W] != '0) ? S_DONE : S_SCAN;
            S_SCAN: begin
                if (hit) begin
                    n_state = S_DONE;
                end else if (scan_end) begin
                    n_state = (is_free || r_total == MAX_CNT) ? S_DONE : S_ADDR;
                end
            end
            S_ADDR:  n_state = S_PLACE;
            S_PLACE: n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_heap_base <= '0;
            r_header    <= HEADER_RESET;
            r_total     <= '0;
            r_heap_top  <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAP_BASE:    r_heap_base <= i_cfg_data;
                    CFG_HEADER_BYTES: r_header    <= i_cfg_data[HDR_W-1:0];
                    default:          r_header    <= r_header;
                endcase
            end

            // scan pointer and read-data tracking
            if (r_state == S_SCAN) begin
                r_chk <= scan_more;
                if (scan_more) begin
                    r_idx <= r_idx + 1'b1;
                end
            end else begin
                r_chk <= 1'b0;
                r_idx <= '0;
            end

            // append bookkeeping
            if (r_state == S_PLACE && place_ok) begin
                r_total    <= r_total + 1'b1;
                r_heap_top <= end_addr[ADDR_W:0];
            end

            // output register
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request data path
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op    <= i_req.payload.operation;
                    r_size  <= i_req.payload.request_size;
                    r_count <= i_req.payload.element_count;
                    r_addr  <= i_req.payload.free_address;
                    r_res   <= '0;
                end
            end
            S_MUL: r_prod <= r_count * r_size;
            S_CHK: begin
                if (r_prod[2*SIZE_W-1:SIZE_W] != '0) begin
                    r_res.status <= ST_TOO_BIG;
                end else begin
                    r_size <= r_prod[SIZE_W-1:0];
                end
            end
            S_SCAN: begin
                if (hit) begin
                    r_res.status       <= ST_OK;
                    r_res.granted_size <= rd_entry.length;
                    if (!is_free) begin
                        r_res.payload_address <= rd_entry.base;
                        r_res.reused_block    <= 1'b1;
                        r_res.zero_fill       <= (r_op == OP_ZALLOC);
                    end
                end else if (scan_end) begin
                    r_res.status <= is_free ? ST_UNKNOWN : ST_NO_ROOM;
                end
            end
            S_ADDR: r_payload <= top_sel + {{(ADDR_W+1-HDR_W){1'b0}}, r_header};
            S_PLACE: begin
                if (place_ok) begin
                    r_res.status          <= ST_OK;
                    r_res.payload_address <= r_payload[ADDR_W-1:0];
                    r_res.granted_size    <= r_size;
                    r_res.zero_fill       <= (r_op == OP_ZALLOC);
                end else begin
                    r_res.status <= ST_NO_ROOM;
                end
            end
            default: r_res <= r_res;
        endcase

        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

`ifndef SYNTHESIS
    // a request always takes the allocator out of the idle state in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("allocator stayed idle after taking a request");

    // table writes only from the scan or the append step
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> (r_state == S_SCAN || r_state == S_PLACE))
        else $error("block table written outside scan or append");

    // the block count only grows, by one, after an append
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE && place_ok) |=> (r_total == $past(r_total) + 1'b1))
        else $error("block count did not follow an append");

    // the block count never passes the table depth
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |-> (r_total < MAX_CNT))
        else $error("append attempted on a full table");
`endif

endmodule
